FILE: rtl/core/pbm_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package pbm_pkg;

	// Field widths
	localparam int unsigned BYTE_W   = 8;
	localparam int unsigned ORIGIN_W = 13;
	localparam int unsigned DIM_W    = 13;
	localparam int unsigned POS_W    = 15;
	localparam int unsigned STATUS_W = 2;

	// Configuration register indexes
	localparam int unsigned CFG_IDX_W = 1;
	localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_X = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Y = 1'b1;

	// Final status codes
	localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
	localparam logic [STATUS_W-1:0] ST_BAD_MAGIC = 2'd1;
	localparam logic [STATUS_W-1:0] ST_BAD_SIZE  = 2'd2;
	localparam logic [STATUS_W-1:0] ST_SHORT     = 2'd3;

	// Result kinds
	localparam logic KIND_PIXEL  = 1'b0;
	localparam logic KIND_STATUS = 1'b1;

	// Result queue depth
	localparam int unsigned RES_DEPTH = 8;
	localparam int unsigned RES_AW    = $clog2(RES_DEPTH);

	typedef struct packed {
		logic                       kind;
		logic signed [POS_W-1:0]    pixel_x;
		logic signed [POS_W-1:0]    pixel_y;
		logic [BYTE_W-1:0]          pixel_mask;
		logic [STATUS_W-1:0]        status;
		logic                       last;
	} pbm_result_t;

	// Results of one byte: up to two, first in r0
	typedef struct packed {
		logic [1:0]  n;
		pbm_result_t r0;
		pbm_result_t r1;
	} pbm_push_t;

endpackage

`default_nettype wire

FILE: rtl/core/pbm_ifs.sv
`timescale 1ns / 1ps
`default_nettype none

interface pbm_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       end_of_file;

	modport source (output valid, output data_byte, output end_of_file, input ready);
	modport sink (input valid, input data_byte, input end_of_file, output ready);
endinterface

interface pbm_out_if;
	logic               valid;
	logic               ready;
	logic               kind;
	logic signed [14:0] pixel_x;
	logic signed [14:0] pixel_y;
	logic [7:0]         pixel_mask;
	logic [1:0]         status;
	logic               last;

	modport source (output valid, output kind, output pixel_x, output pixel_y,
		output pixel_mask, output status, output last, input ready);
	modport sink (input valid, input kind, input pixel_x, input pixel_y,
		input pixel_mask, input status, input last, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/pbm_parser.sv
`timescale 1ns / 1ps
`default_nettype none

module pbm_parser #(
	parameter int unsigned BUFFER_BYTES    = 1024,
	parameter int unsigned SIZE_LINE_CHARS = 31
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                in_fire,
	input  wire logic [pbm_pkg::BYTE_W-1:0]          in_byte,
	input  wire logic                                in_eof,
	input  wire logic signed [pbm_pkg::ORIGIN_W-1:0] origin_x,
	input  wire logic signed [pbm_pkg::ORIGIN_W-1:0] origin_y,
	output pbm_pkg::pbm_push_t                       push
);
	import pbm_pkg::*;

	localparam int unsigned CNT_W = $clog2(BUFFER_BYTES + 1);
	localparam int unsigned SLC_W = $clog2(SIZE_LINE_CHARS + 1);
	localparam int unsigned CMP_W = 32;
	localparam int unsigned PROD_W = 2 * DIM_W;

	localparam logic [CNT_W-1:0] CNT_CAP  = CNT_W'(BUFFER_BYTES);
	localparam logic [SLC_W-1:0] SLC_LAST = SLC_W'(SIZE_LINE_CHARS);
	localparam logic [DIM_W-1:0] DIM_MAX  = {DIM_W{1'b1}};

	// Parse phase codes
	localparam logic [3:0] PH_MAGIC1  = 4'd0;
	localparam logic [3:0] PH_MAGIC2  = 4'd1;
	localparam logic [3:0] PH_SKIP    = 4'd2;
	localparam logic [3:0] PH_COMMENT = 4'd3;
	localparam logic [3:0] PH_WDIG    = 4'd4;
	localparam logic [3:0] PH_WREST   = 4'd5;
	localparam logic [3:0] PH_GAP     = 4'd6;
	localparam logic [3:0] PH_HDIG    = 4'd7;
	localparam logic [3:0] PH_HREST   = 4'd8;
	localparam logic [3:0] PH_NOH     = 4'd9;
	localparam logic [3:0] PH_DATA    = 4'd10;
	localparam logic [3:0] PH_ERR     = 4'd11;

	localparam logic [BYTE_W-1:0] CH_P     = 8'h50;
	localparam logic [BYTE_W-1:0] CH_4     = 8'h34;
	localparam logic [BYTE_W-1:0] CH_HASH  = 8'h23;
	localparam logic [BYTE_W-1:0] CH_LF    = 8'h0A;
	localparam logic [BYTE_W-1:0] CH_SPACE = 8'h20;
	localparam logic [BYTE_W-1:0] CH_TAB   = 8'h09;
	localparam logic [BYTE_W-1:0] CH_VT    = 8'h0B;
	localparam logic [BYTE_W-1:0] CH_FF    = 8'h0C;
	localparam logic [BYTE_W-1:0] CH_CR    = 8'h0D;
	localparam logic [BYTE_W-1:0] CH_NUL   = 8'h00;
	localparam logic [BYTE_W-1:0] CH_0     = 8'h30;
	localparam logic [BYTE_W-1:0] CH_9     = 8'h39;

	function automatic logic [DIM_W-1:0] acc_digit(input logic [DIM_W-1:0] v,
		input logic [3:0] d);
		logic [DIM_W+3:0] n;
		n = ({4'b0, v} << 3) + ({4'b0, v} << 1) + {{DIM_W{1'b0}}, d};
		return (n > {4'b0, DIM_MAX}) ? DIM_MAX : n[DIM_W-1:0];
	endfunction

	function automatic logic missing_h(input logic [3:0] ph);
		return ph == PH_WDIG || ph == PH_WREST || ph == PH_GAP || ph == PH_NOH;
	endfunction

	// Input register
	logic                valid_s1;
	logic [BYTE_W-1:0]   byte_s1;
	logic                eof_s1;

	// Per-file state
	logic [3:0]          ph_q, ph_d;
	logic [DIM_W-1:0]    w_q, w_d, h_q, h_d;
	logic [SLC_W-1:0]    slc_q, slc_d;
	logic [CNT_W-1:0]    cnt_q, cnt_d;
	logic [DIM_W-1:0]    row_q, row_d;
	logic [9:0]          col_q, col_d;
	logic [STATUS_W-1:0] err_q, err_d;
	logic [PROD_W-1:0]   prod_q;

	logic                is_space, is_digit, size_go, pix, short_data, small_ge8;
	logic [3:0]          sp, sp_n, digit;
	logic [SLC_W-1:0]    slc_n;
	logic [10:0]         per_row, col_inc;
	logic [DIM_W-1:0]    col_px, rem;
	logic [5:0]          small_prod;
	logic [BYTE_W-1:0]   mask;
	logic [STATUS_W-1:0] fin_status;
	pbm_result_t         pix_res, stat_res;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= in_fire;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			byte_s1 <= in_byte;
			eof_s1  <= in_eof;
		end
		prod_q <= PROD_W'(w_d) * PROD_W'(h_d);
	end

	assign is_space = byte_s1 == CH_SPACE || byte_s1 == CH_TAB || byte_s1 == CH_LF ||
		byte_s1 == CH_VT || byte_s1 == CH_FF || byte_s1 == CH_CR;
	assign is_digit = byte_s1 >= CH_0 && byte_s1 <= CH_9;
	assign digit    = byte_s1[3:0];

	assign per_row = 11'((14'({1'b0, w_q}) + 14'd7) >> 3);
	assign col_inc = {1'b0, col_q} + 11'd1;
	assign col_px  = {col_q, 3'b000};
	assign rem     = w_q - col_px;
	assign mask    = (rem >= DIM_W'(8)) ? byte_s1 : (byte_s1 & ~(8'hFF >> rem[2:0]));

	always_comb begin
		ph_d    = ph_q;
		w_d     = w_q;
		h_d     = h_q;
		slc_d   = slc_q;
		cnt_d   = cnt_q;
		row_d   = row_q;
		col_d   = col_q;
		err_d   = err_q;
		pix     = 1'b0;
		size_go = 1'b0;
		sp      = ph_q;
		sp_n    = ph_q;
		slc_n   = slc_q + 1'b1;
		if (valid_s1) begin
			unique case (ph_q)
				PH_MAGIC1: begin
					if (byte_s1 == CH_P) begin
						ph_d = PH_MAGIC2;
					end else begin
						ph_d  = PH_ERR;
						err_d = ST_BAD_MAGIC;
					end
				end
				PH_MAGIC2: begin
					if (byte_s1 == CH_4) begin
						ph_d = PH_SKIP;
					end else begin
						ph_d  = PH_ERR;
						err_d = ST_BAD_MAGIC;
					end
				end
				PH_SKIP: begin
					if (byte_s1 == CH_HASH) begin
						ph_d = PH_COMMENT;
					end else if (!is_space) begin
						size_go = 1'b1;
						sp      = PH_WDIG;
						slc_n   = SLC_W'(1);
					end
				end
				PH_COMMENT: begin
					if (byte_s1 == CH_LF) begin
						ph_d = PH_SKIP;
					end
				end
				PH_WDIG, PH_WREST, PH_GAP, PH_HDIG, PH_HREST, PH_NOH: begin
					size_go = 1'b1;
				end
				PH_DATA: begin
					if (cnt_q < CNT_CAP) begin
						cnt_d = cnt_q + 1'b1;
						if (per_row != 11'd0 && row_q < h_q) begin
							pix = 1'b1;
							if (col_inc >= per_row) begin
								col_d = '0;
								row_d = row_q + 1'b1;
							end else begin
								col_d = col_inc[9:0];
							end
						end
					end
				end
				default: ;
			endcase

			if (size_go) begin
				sp_n  = sp;
				slc_d = slc_n;
				unique case (sp)
					PH_WDIG: begin
						if (byte_s1 == CH_NUL) sp_n = PH_NOH;
						else if (byte_s1 == CH_SPACE) sp_n = PH_GAP;
						else if (is_digit) w_d = acc_digit(w_q, digit);
						else sp_n = PH_WREST;
					end
					PH_WREST: begin
						if (byte_s1 == CH_NUL) sp_n = PH_NOH;
						else if (byte_s1 == CH_SPACE) sp_n = PH_GAP;
					end
					PH_GAP: begin
						if (byte_s1 == CH_NUL) begin
							sp_n = PH_NOH;
						end else if (is_digit) begin
							h_d  = {{(DIM_W-4){1'b0}}, digit};
							sp_n = PH_HDIG;
						end else if (byte_s1 != CH_SPACE) begin
							sp_n = PH_HREST;
						end
					end
					PH_HDIG: begin
						if (is_digit) h_d = acc_digit(h_q, digit);
						else sp_n = PH_HREST;
					end
					default: ;
				endcase
				// Close the size line on newline or when it is full
				if (byte_s1 == CH_LF || slc_n >= SLC_LAST) begin
					if (missing_h(sp_n)) begin
						ph_d  = PH_ERR;
						err_d = ST_BAD_SIZE;
					end else begin
						ph_d = PH_DATA;
					end
				end else begin
					ph_d = sp_n;
				end
			end
		end
	end

	// Before the data phase no byte is stored, so short means w*h >= 8
	assign small_prod = {3'b0, w_d[2:0]} * {3'b0, h_d[2:0]};
	assign small_ge8  = w_d != '0 && h_d != '0 &&
		(w_d >= DIM_W'(8) || h_d >= DIM_W'(8) || small_prod >= 6'd8);

	always_comb begin
		if (ph_q == PH_DATA) begin
			short_data = CMP_W'(cnt_d) < CMP_W'(prod_q[PROD_W-1:3]);
		end else begin
			short_data = small_ge8;
		end
		priority if (ph_d == PH_MAGIC1 || ph_d == PH_MAGIC2) begin
			fin_status = ST_BAD_MAGIC;
		end else if (ph_d == PH_SKIP || ph_d == PH_COMMENT) begin
			fin_status = ST_BAD_SIZE;
		end else if (ph_d == PH_ERR) begin
			fin_status = err_d;
		end else if (missing_h(ph_d)) begin
			fin_status = ST_BAD_SIZE;
		end else if (short_data) begin
			fin_status = ST_SHORT;
		end else begin
			fin_status = ST_OK;
		end
	end

	always_comb begin
		pix_res.kind       = KIND_PIXEL;
		pix_res.pixel_x    = POS_W'(origin_x) + $signed({2'b00, col_px});
		pix_res.pixel_y    = POS_W'(origin_y) + $signed({2'b00, row_q});
		pix_res.pixel_mask = mask;
		pix_res.status     = ST_OK;
		pix_res.last       = 1'b0;

		stat_res.kind       = KIND_STATUS;
		stat_res.pixel_x    = '0;
		stat_res.pixel_y    = '0;
		stat_res.pixel_mask = '0;
		stat_res.status     = fin_status;
		stat_res.last       = 1'b1;

		push.n  = {1'b0, pix} + {1'b0, valid_s1 & eof_s1};
		push.r0 = pix ? pix_res : stat_res;
		push.r1 = stat_res;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph_q  <= PH_MAGIC1;
			w_q   <= '0;
			h_q   <= '0;
			slc_q <= '0;
			cnt_q <= '0;
			row_q <= '0;
			col_q <= '0;
			err_q <= ST_OK;
		end else if (valid_s1 && eof_s1) begin
			// Drop all per-file state: the next byte opens a new file
			ph_q  <= PH_MAGIC1;
			w_q   <= '0;
			h_q   <= '0;
			slc_q <= '0;
			cnt_q <= '0;
			row_q <= '0;
			col_q <= '0;
			err_q <= ST_OK;
		end else begin
			ph_q  <= ph_d;
			w_q   <= w_d;
			h_q   <= h_d;
			slc_q <= slc_d;
			cnt_q <= cnt_d;
			row_q <= row_d;
			col_q <= col_d;
			err_q <= err_d;
		end
	end

endmodule

`default_nettype wire

FILE: rtl/core/pbm_res_fifo.sv
`timescale 1ns / 1ps
`default_nettype none

module pbm_res_fifo (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire pbm_pkg::pbm_push_t       push,
	input  wire logic                     pop,
	output pbm_pkg::pbm_result_t          head,
	output logic [pbm_pkg::RES_AW:0]      count
);
	import pbm_pkg::*;

	pbm_result_t       mem_q [RES_DEPTH];
	logic [RES_AW-1:0] wr_ptr_q, rd_ptr_q, wr_ptr_p1;
	logic [RES_AW:0]   count_q;

	assign wr_ptr_p1 = wr_ptr_q + 1'b1;
	assign head      = mem_q[rd_ptr_q];
	assign count     = count_q;

	always_ff @(posedge clk) begin
		if (push.n != 2'd0) mem_q[wr_ptr_q] <= push.r0;
		if (push.n == 2'd2) mem_q[wr_ptr_p1] <= push.r1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + RES_AW'(push.n);
			if (pop) rd_ptr_q <= rd_ptr_q + 1'b1;
			count_q <= count_q + (RES_AW+1)'(push.n) - (RES_AW+1)'(pop);
		end
	end

endmodule

`default_nettype wire

FILE: rtl/core/pbm_p4_bitmap_decoder.sv
`timescale 1ns / 1ps
`default_nettype none

// Streaming decoder for binary PBM (P4) images. Bytes of a file arrive one per
// transfer on in_ch, with end_of_file set on the last one. The decoder checks
// the "P4" magic, skips whitespace and '#' comment lines, reads width and height
// from the size line (saturating at 8191) and then emits one pixel result per
// data byte that fits the buffer capacity and the declared rows: the display
// position of its leftmost pixel (origin_x/origin_y added) and a mask, MSB
// first, with pixels past the image width cleared. The last byte of a file also
// emits a status result with last set; when its status is not zero, discard the
// pixel results of that file. Rate: one byte per clock cycle sustained while
// out_ch takes results. A byte is registered on transfer and decoded in the
// following cycle straight into an eight-entry result queue, from which its
// results go out on out_ch. The queue drains one result per cycle while
// out_ch.ready is high; the last byte of a file may give two results, and
// in_ch.ready drops only when the queue cannot hold the results of the byte in
// flight plus a new one. Write origin_x (index 0) and origin_y (index 1) only
// while the decoder is idle.
module pbm_p4_bitmap_decoder #(
	parameter int unsigned BUFFER_BYTES    = 1024,
	parameter int unsigned SIZE_LINE_CHARS = 31
) (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 cfg_we,
	input  wire logic [pbm_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  wire logic [pbm_pkg::ORIGIN_W-1:0]         cfg_data,
	pbm_in_if.sink                                    in_ch,
	pbm_out_if.source                                 out_ch
);
	import pbm_pkg::*;

	// Room needed: two results for the byte in decode, two for a new transfer
	localparam logic [RES_AW:0] ROOM_LIMIT = (RES_AW+1)'(RES_DEPTH - 2);

	logic signed [ORIGIN_W-1:0] origin_x_q, origin_y_q;
	logic                       in_fire, busy_s1, out_fire;
	logic [RES_AW:0]            q_count;
	pbm_push_t                  push;
	pbm_result_t                head;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			origin_x_q <= '0;
			origin_y_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_ORIGIN_X: origin_x_q <= cfg_data;
				REG_ORIGIN_Y: origin_y_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Track whether a byte sits in the decode register this cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_s1 <= 1'b0;
		end else begin
			busy_s1 <= in_fire;
		end
	end

	// Hold ready off only when the queue could overflow
	assign in_ch.ready = (q_count + (busy_s1 ? (RES_AW+1)'(2) : '0)) <= ROOM_LIMIT;
	assign in_fire     = in_ch.valid & in_ch.ready;

	pbm_parser #(
		.BUFFER_BYTES    (BUFFER_BYTES),
		.SIZE_LINE_CHARS (SIZE_LINE_CHARS)
	) u_parser (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_fire  (in_fire),
		.in_byte  (in_ch.data_byte),
		.in_eof   (in_ch.end_of_file),
		.origin_x (origin_x_q),
		.origin_y (origin_y_q),
		.push     (push)
	);

	// Advance the queue on every output transfer
	assign out_fire = out_ch.valid & out_ch.ready;

	pbm_res_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.pop    (out_fire),
		.head   (head),
		.count  (q_count)
	);

	assign out_ch.valid      = q_count != '0;
	assign out_ch.kind       = head.kind;
	assign out_ch.pixel_x    = head.pixel_x;
	assign out_ch.pixel_y    = head.pixel_y;
	assign out_ch.pixel_mask = head.pixel_mask;
	assign out_ch.status     = head.status;
	assign out_ch.last       = head.last;

endmodule

`default_nettype wire

FILE: rtl/core/pbm_chk.sv
`timescale 1ns / 1ps
`default_nettype none

module pbm_chk (
	input wire logic              clk,
	input wire logic              arst_n,
	input wire logic              out_valid,
	input wire logic              out_ready,
	input wire logic              out_kind,
	input wire logic [14:0]       out_pixel_x,
	input wire logic [14:0]       out_pixel_y,
	input wire logic [7:0]        out_pixel_mask,
	input wire logic [1:0]        out_status,
	input wire logic              out_last
);
	import pbm_pkg::*;

	// A stalled result holds its kind, mask, status and last flag
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_kind) &&
		$stable(out_pixel_mask) && $stable(out_status) && $stable(out_last))
		else $error("result changed while stalled");

	// Only status results close a file
	a_last_kind: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_last == out_kind)
		else $error("last flag disagrees with result kind");

	// Status results carry no pixels
	a_status_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_kind == KIND_STATUS |->
		out_pixel_x == '0 && out_pixel_y == '0 && out_pixel_mask == '0)
		else $error("status result carries pixel data");

	// Pixel results carry status OK
	a_pixel_ok: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_kind == KIND_PIXEL |-> out_status == ST_OK)
		else $error("pixel result carries a status");

endmodule

bind pbm_p4_bitmap_decoder pbm_chk u_chk (
	.clk            (clk),
	.arst_n         (arst_n),
	.out_valid      (out_ch.valid),
	.out_ready      (out_ch.ready),
	.out_kind       (out_ch.kind),
	.out_pixel_x    (out_ch.pixel_x),
	.out_pixel_y    (out_ch.pixel_y),
	.out_pixel_mask (out_ch.pixel_mask),
	.out_status     (out_ch.status),
	.out_last       (out_ch.last)
);

`default_nettype wire
